// ===== rtl/core/caf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_pkg
// Shared types and constants for the crib alignment filter.
// ----------------------------------------------------------------------------
package caf_pkg;

  localparam int SLOT_W          = 5;
  localparam int CHAR_W          = 8;
  localparam int CFG_W           = 6;
  localparam int MAX_CRIB_DEF    = 32;
  localparam int MAX_MESSAGE_DEF = 1024;

  // Item function codes
  localparam logic FUNC_CRIB   = 1'b0;
  localparam logic FUNC_CIPHER = 1'b1;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic              shift;
    logic [CHAR_W-1:0] ch;
  } caf_cell_ctl_t;

endpackage

// ===== rtl/core/crib_alignment_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crib_alignment_filter
// Reports every ciphertext position where the crib lies with no clash.
// ----------------------------------------------------------------------------
// Usage:
//   Load the crib with in_func = crib write, one character per transaction
//   into in_slot; set the crib length through cfg_wr_en / cfg_wr_data while
//   the block is idle. Then send ciphertext characters with in_func = cipher,
//   in_first marking the first character of a message.
//   Each cipher transaction shifts the alignment flags one cell down the
//   chain of MAX_CRIB cells; the cell at crib length minus one yields at
//   most one result, the start position of the finished alignment.
//   Throughput is one transaction per cycle while in_stall is low; the cells
//   compare combinationally and a result is registered in the output register,
//   or in the skid register when the output register is stalled.
//   A stalled result is held; one more result fits in a skid register, and
//   in_stall rises only while that skid register is full.
//   Reset clears the flags, the position count and output valids, and sets
//   the crib length to one. Crib characters are undefined until written.
// ----------------------------------------------------------------------------
module crib_alignment_filter
  import caf_pkg::*;
#(
  parameter int MAX_CRIB    = MAX_CRIB_DEF,
  parameter int MAX_MESSAGE = MAX_MESSAGE_DEF,
  localparam int POS_W      = $clog2(MAX_MESSAGE),
  localparam int CIDX_W     = (MAX_CRIB > 1) ? $clog2(MAX_CRIB) : 1
)
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [CHAR_W-1:0] in_char_value,
  input  logic              in_first,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [POS_W-1:0]  out_start_position,
  output logic              out_position_saturated
);

  localparam int CMP_W   = ((POS_W > CIDX_W) ? POS_W : CIDX_W) + 1;
  localparam int LEN_W   = (CFG_W > CIDX_W + 1) ? CFG_W + 1 : CIDX_W + 2;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_MESSAGE - 1);

  // configuration: keep crib length minus one, clamped
  logic [CIDX_W-1:0] len_m1_r;
  logic [CIDX_W-1:0] len_m1_nxt;

  always_comb begin
    if (cfg_wr_data == '0) begin
      len_m1_nxt = '0;
    end else if (LEN_W'(cfg_wr_data) > LEN_W'(MAX_CRIB)) begin
      len_m1_nxt = CIDX_W'(MAX_CRIB - 1);
    end else begin
      len_m1_nxt = CIDX_W'(cfg_wr_data - CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_m1_r <= '0;
    end else if (cfg_wr_en) begin
      len_m1_r <= len_m1_nxt;
    end
  end

  // input acceptance
  logic skid_full_r;
  logic accept;
  logic cipher_acc;
  logic crib_acc;

  assign in_stall   = skid_full_r;
  assign accept     = in_valid & ~skid_full_r;
  assign cipher_acc = accept & (in_func == FUNC_CIPHER);
  assign crib_acc   = accept & (in_func == FUNC_CRIB);

  // chain of cells
  caf_cell_ctl_t ctl;
  logic          flag_q   [MAX_CRIB];
  logic          flag_nxt [MAX_CRIB];

  assign ctl.shift = cipher_acc;
  assign ctl.ch    = in_char_value;

  for (genvar k = 0; k < MAX_CRIB; k++) begin : g_cell
    logic chain;
    logic wr;

    if (k == 0) begin : g_head
      assign chain = 1'b1;
    end else begin : g_link
      // a new message clears the alignments in flight
      assign chain = flag_q[k-1] & ~in_first;
    end

    if (k < (1 << SLOT_W)) begin : g_wr
      assign wr = crib_acc & (in_slot == SLOT_W'(k));
    end else begin : g_nowr
      assign wr = 1'b0;
    end

    caf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .wr_en      (wr),
      .chain_in   (chain),
      .flag_o     (flag_q[k]),
      .flag_nxt_o (flag_nxt[k])
    );
  end

  // position count
  logic [POS_W-1:0] idx_r;
  logic [POS_W-1:0] idx_nxt;
  logic             sat_r;
  logic             sat_nxt;
  logic [POS_W-1:0] idx_cur;
  logic             sat_cur;

  assign idx_cur = in_first ? '0 : idx_r;
  assign sat_cur = in_first ? 1'b0 : sat_r;

  always_comb begin
    idx_nxt = idx_r;
    sat_nxt = sat_r;
    if (cipher_acc) begin
      if (idx_cur >= LAST_POS) begin
        idx_nxt = LAST_POS;
        sat_nxt = 1'b1;
      end else begin
        idx_nxt = idx_cur + POS_W'(1);
        sat_nxt = sat_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      sat_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      sat_r <= sat_nxt;
    end
  end

  // result of the current transaction
  logic             res_valid;
  logic [POS_W-1:0] res_start;
  logic [CMP_W-1:0] diff;

  assign res_valid = cipher_acc & flag_nxt[len_m1_r];
  assign diff      = CMP_W'(idx_cur) - CMP_W'(len_m1_r);

  always_comb begin
    if (sat_cur) begin
      res_start = LAST_POS;
    end else if (CMP_W'(idx_cur) >= CMP_W'(len_m1_r)) begin
      res_start = diff[POS_W-1:0];
    end else begin
      res_start = '0;
    end
  end

  // output register and skid register
  logic             out_valid_r;
  logic [POS_W-1:0] out_start_r;
  logic             out_sat_r;
  logic [POS_W-1:0] skid_start_r;
  logic             skid_sat_r;
  logic             out_free;

  assign out_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_free) begin
      if (skid_full_r) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_full_r) begin
        out_start_r <= skid_start_r;
        out_sat_r   <= skid_sat_r;
      end else begin
        out_start_r <= res_start;
        out_sat_r   <= sat_cur;
      end
    end else if (res_valid) begin
      // hold the new result behind the stalled one
      skid_start_r <= res_start;
      skid_sat_r   <= sat_cur;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_start_position     = out_start_r;
  assign out_position_saturated = out_sat_r;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid register full with empty output register");

  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (idx_r == LAST_POS))
    else $error("saturated position count not clamped");

  a_sat_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_start_r == LAST_POS))
    else $error("saturated result with unclamped start position");

  a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cipher_acc && in_first) |=> (idx_r == POS_W'(1)) && !sat_r)
    else $error("first character did not restart the position count");

endmodule

// ===== rtl/core/caf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_cell
// One crib cell: holds a crib character and the no-clash flag of the
// alignment that has reached this cell, passed on to the next cell.
// ----------------------------------------------------------------------------
module caf_cell
  import caf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  caf_cell_ctl_t ctl,
  input  logic          wr_en,
  input  logic          chain_in,
  output logic          flag_o,
  output logic          flag_nxt_o
);

  logic [CHAR_W-1:0] crib_r;
  logic              flag_r;
  logic              flag_nxt;

  always_comb begin
    flag_nxt = flag_r;
    if (ctl.shift) begin
      // drop the alignment if the crib letter equals the cipher letter
      flag_nxt = chain_in & (crib_r != ctl.ch);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      crib_r <= ctl.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  assign flag_o     = flag_r;
  assign flag_nxt_o = flag_nxt;

endmodule
